@@ design/pese_pkg.sv @@
// ----------------------------------------------------------------------------
// pese_pkg
// Shared types and constants for the prefix expression stack evaluator.
// ----------------------------------------------------------------------------
package pese_pkg;

  localparam int unsigned DataW             = 32;
  localparam int unsigned DivCntW           = $clog2(DataW);
  localparam int unsigned StackDepthDefault = 64;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_REM  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_UNDERFLOW = 2'd1,
    ERR_OVERFLOW  = 2'd2,
    ERR_DIVZERO   = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_READ = 3'd1,
    ST_DIV  = 3'd2,
    ST_WB   = 3'd3,
    ST_FIN  = 3'd4
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quotient;
    logic [DataW-1:0] remainder;
  } div_resp_t;

endpackage

@@ design/prefix_expression_stack_evaluator.sv @@
// Steps: a push is done as it is accepted; add, subtract and multiply go
// through accept, stack read and write back; divide and remainder with a
// nonzero divisor also wait on the divider, one quotient bit per cycle.
// A last token then moves the answer into the output register once it is free.
// Reset clears the stack count, the error code and the output valid; the stack
// memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// prefix_expression_stack_evaluator
// Evaluates prefix expressions fed last token first, using an operand stack
// kept in a synchronous memory with the top entry mirrored in a register.
// ----------------------------------------------------------------------------
module prefix_expression_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = pese_pkg::StackDepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [2:0]                        op_i,
  input  logic signed [pese_pkg::DataW-1:0] value_i,
  input  logic                              last_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [pese_pkg::DataW-1:0] result_o,
  output logic [1:0]                        error_o
);

  localparam int unsigned W     = pese_pkg::DataW;
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);

  pese_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  pese_pkg::err_e   err_q, err_d;
  logic [W-1:0]     tos_q, tos_d;
  pese_pkg::op_e    op_q, op_d;
  logic             last_q, last_d;
  logic [W-1:0]     res_q, res_d;
  logic             out_valid_q, out_valid_d;
  logic [W-1:0]     result_q, result_d;
  pese_pkg::err_e   error_q, error_d;

  logic             accept;
  logic             can_pop;
  logic             can_push;
  logic             out_free;
  logic [CntW-1:0]  cnt_m2;
  logic             is_divop;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [W-1:0]     mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  logic [W-1:0]     mem_rdata;

  pese_pkg::div_req_t  div_req;
  pese_pkg::div_resp_t div_resp;

  assign in_ready_o = (state_q == pese_pkg::ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign can_pop    = (cnt_q >= CntW'(2));
  assign can_push   = (cnt_q < CntW'(STACK_DEPTH));
  assign out_free   = ~out_valid_q | out_ready_i;
  assign cnt_m2     = cnt_q - CntW'(2);
  assign is_divop   = (op_q == pese_pkg::OP_DIV) || (op_q == pese_pkg::OP_REM);

  pese_stack_mem #(
    .Depth (STACK_DEPTH),
    .AddrW (AddrW)
  ) u_stack_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pese_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .resp_o (div_resp)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pese_pkg::ST_IDLE: begin
        if (accept) begin
          if (op_i >= 3'(pese_pkg::OP_ADD) && op_i <= 3'(pese_pkg::OP_REM) && can_pop) begin
            state_d = pese_pkg::ST_READ;
          end else if (last_i) begin
            state_d = pese_pkg::ST_FIN;
          end
        end
      end
      pese_pkg::ST_READ: begin
        if (is_divop && (mem_rdata != '0)) begin
          state_d = pese_pkg::ST_DIV;
        end else begin
          state_d = pese_pkg::ST_WB;
        end
      end
      pese_pkg::ST_DIV: begin
        if (div_resp.done) begin
          state_d = pese_pkg::ST_WB;
        end
      end
      pese_pkg::ST_WB: begin
        state_d = last_q ? pese_pkg::ST_FIN : pese_pkg::ST_IDLE;
      end
      pese_pkg::ST_FIN: begin
        if (out_free) begin
          state_d = pese_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pese_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    cnt_d            = cnt_q;
    err_d            = err_q;
    tos_d            = tos_q;
    op_d             = op_q;
    last_d           = last_q;
    res_d            = res_q;
    out_valid_d      = out_valid_q & ~out_ready_i;
    result_d         = result_q;
    error_d          = error_q;
    mem_we           = 1'b0;
    mem_waddr        = cnt_q[AddrW-1:0];
    mem_wdata        = value_i;
    mem_raddr        = cnt_m2[AddrW-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = tos_q;
    div_req.divisor  = mem_rdata;

    case (state_q)
      pese_pkg::ST_IDLE: begin
        if (accept) begin
          op_d   = pese_pkg::op_e'(op_i);
          last_d = last_i;
          case (op_i)
            3'(pese_pkg::OP_PUSH): begin
              if (can_push) begin
                mem_we = 1'b1;
                tos_d  = value_i;
                cnt_d  = cnt_q + 1'b1;
              end else if (err_q == pese_pkg::ERR_OK) begin
                err_d = pese_pkg::ERR_OVERFLOW;
              end
            end
            3'(pese_pkg::OP_ADD), 3'(pese_pkg::OP_SUB), 3'(pese_pkg::OP_MUL),
            3'(pese_pkg::OP_DIV), 3'(pese_pkg::OP_REM): begin
              if (!can_pop && (err_q == pese_pkg::ERR_OK)) begin
                err_d = pese_pkg::ERR_UNDERFLOW;
              end
            end
            default: begin
            end
          endcase
        end
      end
      pese_pkg::ST_READ: begin
        // The top entry is the left operand, the memory word the right one.
        case (op_q)
          pese_pkg::OP_ADD: res_d = tos_q + mem_rdata;
          pese_pkg::OP_SUB: res_d = tos_q - mem_rdata;
          pese_pkg::OP_MUL: res_d = tos_q * mem_rdata;
          pese_pkg::OP_DIV, pese_pkg::OP_REM: begin
            if (mem_rdata == '0) begin
              res_d = '0;
              if (err_q == pese_pkg::ERR_OK) begin
                err_d = pese_pkg::ERR_DIVZERO;
              end
            end else begin
              div_req.start = 1'b1;
            end
          end
          default: res_d = tos_q;
        endcase
      end
      pese_pkg::ST_DIV: begin
        if (div_resp.done) begin
          res_d = (op_q == pese_pkg::OP_DIV) ? div_resp.quotient : div_resp.remainder;
        end
      end
      pese_pkg::ST_WB: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_m2[AddrW-1:0];
        mem_wdata = res_q;
        tos_d     = res_q;
        cnt_d     = cnt_q - 1'b1;
      end
      pese_pkg::ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          result_d    = (cnt_q != '0) ? tos_q : '0;
          error_d     = err_q;
          cnt_d       = '0;
          err_d       = pese_pkg::ERR_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pese_pkg::ST_IDLE;
      cnt_q       <= '0;
      err_q       <= pese_pkg::ERR_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q    <= tos_d;
    op_q     <= op_d;
    last_q   <= last_d;
    res_q    <= res_d;
    result_q <= result_d;
    error_q  <= error_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign error_o     = error_q;

endmodule

@@ design/pese_stack_mem.sv @@
// ----------------------------------------------------------------------------
// pese_stack_mem
// Operand stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pese_stack_mem #(
  parameter int unsigned Depth = pese_pkg::StackDepthDefault,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [pese_pkg::DataW-1:0] wdata_i,
  input  logic [AddrW-1:0]           raddr_i,
  output logic [pese_pkg::DataW-1:0] rdata_o
);

  logic [pese_pkg::DataW-1:0] mem_q [Depth];
  logic [pese_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/pese_divider.sv @@
// ----------------------------------------------------------------------------
// pese_divider
// Iterative signed divider: one quotient bit per cycle on magnitudes, then a
// sign fix step. Quotient truncates toward zero.
// ----------------------------------------------------------------------------
module pese_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pese_pkg::div_req_t  req_i,
  output pese_pkg::div_resp_t resp_o
);

  localparam int unsigned W = pese_pkg::DataW;

  logic                        busy_q, fix_q, done_q;
  logic [pese_pkg::DivCntW-1:0] cnt_q;
  logic [W-1:0]                a_q, d_q, r_q;
  logic                        neg_q_q, neg_r_q;
  logic [W-1:0]                quot_q, rem_q;

  logic [W:0]   trial;
  logic [W:0]   diff;
  logic         fits;

  assign trial = {r_q, a_q[W-1]};
  assign diff  = trial - {1'b0, d_q};
  assign fits  = ~diff[W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        fix_q  <= 1'b0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == pese_pkg::DivCntW'(W - 1)) begin
          busy_q <= 1'b0;
          fix_q  <= 1'b1;
        end
      end else if (fix_q) begin
        fix_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q     <= req_i.dividend[W-1] ? -req_i.dividend : req_i.dividend;
      d_q     <= req_i.divisor[W-1] ? -req_i.divisor : req_i.divisor;
      r_q     <= '0;
      neg_q_q <= req_i.dividend[W-1] ^ req_i.divisor[W-1];
      neg_r_q <= req_i.dividend[W-1];
    end else if (busy_q) begin
      r_q <= fits ? diff[W-1:0] : trial[W-1:0];
      a_q <= {a_q[W-2:0], fits};
    end else if (fix_q) begin
      // The most negative dividend over -1 wraps back to itself here.
      quot_q <= neg_q_q ? -a_q : a_q;
      rem_q  <= neg_r_q ? -r_q : r_q;
    end
  end

  assign resp_o.done      = done_q;
  assign resp_o.quotient  = quot_q;
  assign resp_o.remainder = rem_q;

endmodule
